### src/gds_pkg.sv
// Shared widths, codes, job record and helper functions of the divergence stencil.
`default_nettype none

package gds_pkg;

   localparam int VEL_W      = 16;
   localparam int WORD_W     = 2 * VEL_W;
   localparam int DIV_W      = 16;
   localparam int COL_OUT_W  = 8;
   localparam int ROW_W      = 12;
   localparam int GW_W       = 9;
   localparam int GH_W       = 13;
   localparam int SCALE_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int MAX_HEIGHT = 4096;
   localparam int SUM_W      = 20;
   localparam int PROD_W     = SUM_W + SCALE_W + 1;
   localparam int FRAC_W     = 8;
   localparam int DIV_MAX    = 32767;
   localparam int DIV_MIN    = -32768;
   localparam int QUEUE_DEPTH = 4;
   localparam int LEVEL_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int NUM_EMIT   = 3;

   // Bit positions of the three possible results of one cell in a job mask.
   localparam int EMIT_UP   = 0;
   localparam int EMIT_LEFT = 1;
   localparam int EMIT_SELF = 2;

   localparam logic [GW_W-1:0]    GRID_WIDTH_RESET  = 9'd256;
   localparam logic [GH_W-1:0]    GRID_HEIGHT_RESET = 13'd256;
   localparam logic [SCALE_W-1:0] INV_TWO_DX_RESET  = 16'd128;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GRID_WIDTH  = 2'd0,
      REG_GRID_HEIGHT = 2'd1,
      REG_INV_TWO_DX  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] sum_up;
      logic signed [SUM_W-1:0] sum_left;
      logic signed [SUM_W-1:0] sum_self;
      logic [COL_OUT_W-1:0]    col;
      logic [ROW_W-1:0]        row;
      logic [NUM_EMIT-1:0]     mask;
   } job_type;

   function automatic logic signed [SUM_W-1:0] widen(input logic signed [VEL_W-1:0] v);
      return SUM_W'(v);
   endfunction

   function automatic logic signed [SUM_W-1:0] negate(input logic signed [VEL_W-1:0] v);
      return -SUM_W'(v);
   endfunction

endpackage

`default_nettype wire

### src/gds_if.sv
// Handshake channel interfaces for cell words, result words and register writes.
`default_nettype none

interface gds_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [gds_pkg::VEL_W-1:0]  vel_x;
   logic signed [gds_pkg::VEL_W-1:0]  vel_y;

   modport source (output valid, output vel_x, output vel_y, input ready);
   modport sink   (input valid, input vel_x, input vel_y, output ready);
endinterface

interface gds_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [gds_pkg::DIV_W-1:0]    div_value;
   logic [gds_pkg::COL_OUT_W-1:0]       out_col;
   logic [gds_pkg::ROW_W-1:0]           out_row;
   logic                                last_of_run;

   modport source (output valid, output div_value, output out_col, output out_row,
                   output last_of_run, input ready);
   modport sink   (input valid, input div_value, input out_col, input out_row,
                   input last_of_run, output ready);
endinterface

interface gds_csr_if;
   logic                              valid;
   logic                              ready;
   logic [gds_pkg::CSR_IDX_W-1:0]     index;
   logic [gds_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/gds_ram.sv
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module gds_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_a_addr];
      rd_b_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

`default_nettype wire

### src/gds_fifo.sv
// Short job queue between the classifying front end and the arithmetic back end.
`default_nettype none

module gds_fifo (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  gds_pkg::job_type               push_job,
   input  logic                           pop,
   output logic                           head_valid,
   output gds_pkg::job_type               head_job,
   output logic [gds_pkg::LEVEL_W-1:0]    level
);

   localparam int PTR_W = $clog2(gds_pkg::QUEUE_DEPTH);

   gds_pkg::job_type              entry_ff [gds_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]              wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]              rd_ptr_ff, rd_ptr_in;
   logic [gds_pkg::LEVEL_W-1:0]   level_ff, level_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(gds_pkg::QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(gds_pkg::QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         level_in = level_ff + gds_pkg::LEVEL_W'(1);
      end else if (pop && !push) begin
         level_in = level_ff - gds_pkg::LEVEL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_valid = (level_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign level      = level_ff;

endmodule

`default_nettype wire

### src/gds_front.sv
// Front end: raster position tracking, row buffers, stencil window and term sums.
`default_nettype none

module gds_front #(
   parameter int MAX_WIDTH = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   gds_req_if.sink                           req_port,
   input  logic [gds_pkg::GW_W-1:0]          grid_width,
   input  logic [gds_pkg::GH_W-1:0]          grid_height,
   input  logic [gds_pkg::LEVEL_W-1:0]       level,
   output logic                              push,
   output gds_pkg::job_type                  push_job
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int CNT_W  = COL_W + 1;
   localparam int DEPTH  = 3 * MAX_WIDTH;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int LW1    = gds_pkg::LEVEL_W + 1;
   localparam int VW     = gds_pkg::VEL_W;
   localparam int GH_W   = gds_pkg::GH_W;
   localparam int ROW_W  = gds_pkg::ROW_W;

   typedef struct packed {
      logic up;
      logic up_two;
      logic left;
      logic left_two;
      logic col_last;
      logic row_last;
   } flags_type;

   function automatic logic [1:0] slot_next(input logic [1:0] s);
      logic [1:0] result;
      case (s)
         2'd0:    result = 2'd1;
         2'd1:    result = 2'd2;
         default: result = 2'd0;
      endcase
      return result;
   endfunction

   function automatic logic [1:0] slot_prev(input logic [1:0] s);
      logic [1:0] result;
      case (s)
         2'd1:    result = 2'd0;
         2'd2:    result = 2'd1;
         default: result = 2'd2;
      endcase
      return result;
   endfunction

   function automatic logic [ADDR_W-1:0] slot_base(input logic [1:0] s);
      logic [ADDR_W-1:0] result;
      case (s)
         2'd1:    result = ADDR_W'(MAX_WIDTH);
         2'd2:    result = ADDR_W'(2 * MAX_WIDTH);
         default: result = '0;
      endcase
      return result;
   endfunction

   // Raster position of the next cell and its row buffer slot (row mod 3).
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [1:0]        slot_ff, slot_in;

   logic [CNT_W-1:0]  w_eff;
   logic [GH_W-1:0]   h_eff;
   logic [COL_W-1:0]  c_cur;
   logic [ROW_W-1:0]  r_cur;
   logic [GH_W-1:0]   row_pre;
   logic [1:0]        slot_pre, slot_cur;
   logic [CNT_W-1:0]  c_plus;
   logic [COL_W-1:0]  lead_col;
   flags_type         flags_cur;
   logic [LW1-1:0]    pending;
   logic              accept;

   logic [ADDR_W-1:0]            wr_addr, rd_a_addr, rd_b_addr;
   logic [gds_pkg::WORD_W-1:0]   rd_a_data, rd_b_data;

   // Stage one: the accepted cell while its buffer reads complete.
   logic                     s1_valid_ff;
   logic [COL_W-1:0]         s1_col_ff;
   logic [ROW_W-1:0]         s1_row_ff;
   logic signed [VW-1:0]     s1_vx_ff, s1_vy_ff;
   flags_type                s1_flags_ff;

   // Stencil window on the row above and the last cells of the current row.
   logic [gds_pkg::WORD_W-1:0]  win_b_ff, win_c_ff, first_ff;
   logic signed [VW-1:0]        cur_x1_ff, cur_y1_ff, cur_x2_ff;

   logic [gds_pkg::WORD_W-1:0]  a_word, b_word;
   logic signed [VW-1:0]        a_x, a_y, b_x, b_y, c_x, rb_y;
   logic [31:0]                 col_wide;
   gds_pkg::job_type            job;

   always_comb begin
      if (grid_width == '0) begin
         w_eff = CNT_W'(1);
      end else if (32'(grid_width) > MAX_WIDTH) begin
         w_eff = CNT_W'(MAX_WIDTH);
      end else begin
         w_eff = CNT_W'(grid_width);
      end
      if (grid_height == '0) begin
         h_eff = GH_W'(1);
      end else if (grid_height > GH_W'(gds_pkg::MAX_HEIGHT)) begin
         h_eff = GH_W'(gds_pkg::MAX_HEIGHT);
      end else begin
         h_eff = grid_height;
      end
   end

   // A stored position past a shrunken geometry wraps before the cell is placed.
   always_comb begin
      if (CNT_W'(col_ff) >= w_eff) begin
         c_cur    = '0;
         row_pre  = GH_W'(row_ff) + GH_W'(1);
         slot_pre = slot_next(slot_ff);
      end else begin
         c_cur    = col_ff;
         row_pre  = GH_W'(row_ff);
         slot_pre = slot_ff;
      end
      if (row_pre >= h_eff) begin
         r_cur    = '0;
         slot_cur = 2'd0;
      end else begin
         r_cur    = row_pre[ROW_W-1:0];
         slot_cur = slot_pre;
      end
      c_plus             = CNT_W'(c_cur) + CNT_W'(1);
      flags_cur.up       = (r_cur != '0);
      flags_cur.up_two   = (r_cur > ROW_W'(1));
      flags_cur.left     = (c_cur != '0);
      flags_cur.left_two = (CNT_W'(c_cur) > CNT_W'(1));
      flags_cur.col_last = (c_plus == w_eff);
      flags_cur.row_last = ((GH_W'(r_cur) + GH_W'(1)) == h_eff);
      lead_col           = (c_plus == CNT_W'(MAX_WIDTH)) ? '0 : c_plus[COL_W-1:0];
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      slot_in = slot_ff;
      if (accept) begin
         if (flags_cur.col_last) begin
            col_in = '0;
            if (flags_cur.row_last) begin
               row_in  = '0;
               slot_in = 2'd0;
            end else begin
               row_in  = r_cur + ROW_W'(1);
               slot_in = slot_next(slot_cur);
            end
         end else begin
            col_in  = c_plus[COL_W-1:0];
            row_in  = r_cur;
            slot_in = slot_cur;
         end
      end
   end

   // Room is reserved for the cell in stage one as well as the new one.
   assign pending        = LW1'(level) + LW1'(s1_valid_ff);
   assign req_port.ready = (pending < LW1'(gds_pkg::QUEUE_DEPTH));
   assign accept         = req_port.valid && req_port.ready;

   assign wr_addr   = slot_base(slot_cur) + ADDR_W'(c_cur);
   assign rd_a_addr = slot_base(slot_prev(slot_cur)) + ADDR_W'(lead_col);
   assign rd_b_addr = slot_base(slot_next(slot_cur)) + ADDR_W'(c_cur);

   gds_ram #(
      .WIDTH (gds_pkg::WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (accept),
      .wr_addr   (wr_addr),
      .wr_data   ({req_port.vel_y, req_port.vel_x}),
      .rd_a_addr (rd_a_addr),
      .rd_a_data (rd_a_data),
      .rd_b_addr (rd_b_addr),
      .rd_b_data (rd_b_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         slot_ff     <= 2'd0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         slot_ff     <= slot_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff   <= c_cur;
         s1_row_ff   <= r_cur;
         s1_vx_ff    <= req_port.vel_x;
         s1_vy_ff    <= req_port.vel_y;
         s1_flags_ff <= flags_cur;
      end
   end

   // The row above: A is column c-1, B column c, C column c+1 (just read).
   // Column zero of the row above comes from the copy kept at its start.
   always_comb begin
      a_word = win_b_ff;
      b_word = s1_flags_ff.left ? win_c_ff : first_ff;
      a_x    = $signed(a_word[VW-1:0]);
      a_y    = $signed(a_word[2*VW-1:VW]);
      b_x    = $signed(b_word[VW-1:0]);
      b_y    = $signed(b_word[2*VW-1:VW]);
      c_x    = $signed(rd_a_data[VW-1:0]);
      rb_y   = $signed(rd_b_data[2*VW-1:VW]);
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         win_b_ff  <= b_word;
         win_c_ff  <= rd_a_data;
         cur_x1_ff <= s1_vx_ff;
         cur_y1_ff <= s1_vy_ff;
         cur_x2_ff <= cur_x1_ff;
         if (!s1_flags_ff.left) begin
            first_ff <= {s1_vy_ff, s1_vx_ff};
         end
      end
   end

   // Edge neighbors are reflected: the cell's own component with its sign flipped.
   always_comb begin
      col_wide = 32'(s1_col_ff);

      job.sum_up = (s1_flags_ff.left ? gds_pkg::negate(a_x) : gds_pkg::widen(b_x))
                 + (s1_flags_ff.col_last ? gds_pkg::negate(b_x) : gds_pkg::widen(c_x))
                 + (s1_flags_ff.up_two ? gds_pkg::negate(rb_y) : gds_pkg::widen(b_y))
                 + gds_pkg::widen(s1_vy_ff);

      job.sum_left = (s1_flags_ff.left_two ? gds_pkg::negate(cur_x2_ff) :
                                             gds_pkg::widen(cur_x1_ff))
                   + gds_pkg::widen(s1_vx_ff)
                   + (s1_flags_ff.up ? gds_pkg::negate(a_y) : gds_pkg::widen(cur_y1_ff))
                   + gds_pkg::negate(cur_y1_ff);

      job.sum_self = (s1_flags_ff.left ? gds_pkg::negate(cur_x1_ff) :
                                         gds_pkg::widen(s1_vx_ff))
                   + gds_pkg::negate(s1_vx_ff)
                   + (s1_flags_ff.up ? gds_pkg::negate(b_y) : gds_pkg::widen(s1_vy_ff))
                   + gds_pkg::negate(s1_vy_ff);

      job.col = col_wide[gds_pkg::COL_OUT_W-1:0];
      job.row = s1_row_ff;
      job.mask[gds_pkg::EMIT_UP]   = s1_flags_ff.up;
      job.mask[gds_pkg::EMIT_LEFT] = s1_flags_ff.row_last && s1_flags_ff.left;
      job.mask[gds_pkg::EMIT_SELF] = s1_flags_ff.row_last && s1_flags_ff.col_last;
   end

   assign push     = s1_valid_ff && (job.mask != '0);
   assign push_job = job;

endmodule

`default_nettype wire

### src/gds_back.sv
// Back end: walks the results of each job, scales, rounds down and saturates.
`default_nettype none

module gds_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             head_valid,
   input  gds_pkg::job_type                 head_job,
   output logic                             pop,
   input  logic [gds_pkg::SCALE_W-1:0]      inv_two_dx,
   gds_rsp_if.source                        rsp_port
);

   localparam int PW = gds_pkg::PROD_W;
   localparam int NE = gds_pkg::NUM_EMIT;

   logic [NE-1:0]                    done_ff, done_in;
   logic [NE-1:0]                    remaining, pick;
   logic                             is_final, advance, take;
   logic signed [gds_pkg::SUM_W-1:0] sel_sum;
   logic [gds_pkg::COL_OUT_W-1:0]    sel_col;
   logic [gds_pkg::ROW_W-1:0]        sel_row;

   logic                             s1_valid_ff;
   logic signed [PW-1:0]             s1_prod_ff;
   logic [gds_pkg::COL_OUT_W-1:0]    s1_col_ff;
   logic [gds_pkg::ROW_W-1:0]        s1_row_ff;
   logic                             s1_last_ff;

   logic signed [PW-1:0]             quot;
   logic signed [gds_pkg::DIV_W-1:0] div_sat;

   logic                             out_valid_ff;
   logic signed [gds_pkg::DIV_W-1:0] out_div_ff;
   logic [gds_pkg::COL_OUT_W-1:0]    out_col_ff;
   logic [gds_pkg::ROW_W-1:0]        out_row_ff;
   logic                             out_last_ff;

   // Results of one cell leave in mask order: the cell above, left, then itself.
   always_comb begin
      remaining = head_job.mask & ~done_ff;
      pick      = remaining & (~remaining + NE'(1));
      is_final  = ((remaining & ~pick) == '0);
      if (pick[gds_pkg::EMIT_UP]) begin
         sel_sum = head_job.sum_up;
         sel_col = head_job.col;
         sel_row = head_job.row - gds_pkg::ROW_W'(1);
      end else if (pick[gds_pkg::EMIT_LEFT]) begin
         sel_sum = head_job.sum_left;
         sel_col = head_job.col - gds_pkg::COL_OUT_W'(1);
         sel_row = head_job.row;
      end else begin
         sel_sum = head_job.sum_self;
         sel_col = head_job.col;
         sel_row = head_job.row;
      end
   end

   assign advance = !out_valid_ff || rsp_port.ready;
   assign take    = advance && head_valid;
   assign pop     = take && is_final;

   always_comb begin
      done_in = done_ff;
      if (take) begin
         done_in = is_final ? '0 : (done_ff | pick);
      end
   end

   // Floor division by 256 is an arithmetic shift of the product.
   always_comb begin
      quot = s1_prod_ff >>> gds_pkg::FRAC_W;
      if (quot > gds_pkg::DIV_MAX) begin
         div_sat = gds_pkg::DIV_W'(gds_pkg::DIV_MAX);
      end else if (quot < gds_pkg::DIV_MIN) begin
         div_sat = gds_pkg::DIV_W'(gds_pkg::DIV_MIN);
      end else begin
         div_sat = quot[gds_pkg::DIV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
         if (advance) begin
            s1_valid_ff  <= head_valid;
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_prod_ff  <= sel_sum * $signed({1'b0, inv_two_dx});
         s1_col_ff   <= sel_col;
         s1_row_ff   <= sel_row;
         s1_last_ff  <= is_final;
         out_div_ff  <= div_sat;
         out_col_ff  <= s1_col_ff;
         out_row_ff  <= s1_row_ff;
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_port.valid       = out_valid_ff;
   assign rsp_port.div_value   = out_div_ff;
   assign rsp_port.out_col     = out_col_ff;
   assign rsp_port.out_row     = out_row_ff;
   assign rsp_port.last_of_run = out_last_ff;

endmodule

`default_nettype wire

### src/grid_divergence_stencil.sv
// Top level of the streaming 2D central-difference divergence block.
//
// Velocity cells enter in raster order, one word per cell, and the block takes one
// cell word per clock cycle unless it stalls the cell input. Each cell below row
// zero releases the divergence of the cell above it; cells of the last row after
// its first column also release their left neighbor, and the last cell of the
// grid releases itself, so the last row yields up to two or three result words
// per cell. The back end issues one result word per cycle unless the output
// stalls; the extra results of the last row are absorbed first by a four-entry
// job queue and then by stalling the cell input. A result word is offered once its
// cell word has passed the row buffer read, the job queue, the back end's product
// register and the saturation into the output register. Three rows of MAX_WIDTH
// words live in one RAM with a write port and two registered read ports; nothing
// clears it after reset, so the block accepts cells from the first cycle. The user
// must write registers through the register port only while the block is idle;
// the block does not enforce this. Grid geometry outside its range is clamped.
`default_nettype none

module grid_divergence_stencil #(
   parameter int MAX_WIDTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   gds_req_if.sink     req_port,
   gds_rsp_if.source   rsp_port,
   gds_csr_if.sink     csr_port
);

   // Configuration registers, always ready for a write word.
   logic [gds_pkg::GW_W-1:0]      grid_width_ff;
   logic [gds_pkg::GH_W-1:0]      grid_height_ff;
   logic [gds_pkg::SCALE_W-1:0]   inv_two_dx_ff;

   // Queue between the front end and the back end.
   logic                          push;
   gds_pkg::job_type              push_job;
   logic                          pop;
   logic                          head_valid;
   gds_pkg::job_type              head_job;
   logic [gds_pkg::LEVEL_W-1:0]   level;

   assign csr_port.ready = 1'b1;

   // Writes to an index beyond the register list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= gds_pkg::GRID_WIDTH_RESET;
         grid_height_ff <= gds_pkg::GRID_HEIGHT_RESET;
         inv_two_dx_ff  <= gds_pkg::INV_TWO_DX_RESET;
      end else if (csr_port.valid && csr_port.ready) begin
         case (csr_port.index)
            gds_pkg::REG_GRID_WIDTH: begin
               grid_width_ff <= csr_port.data[gds_pkg::GW_W-1:0];
            end
            gds_pkg::REG_GRID_HEIGHT: begin
               grid_height_ff <= csr_port.data[gds_pkg::GH_W-1:0];
            end
            gds_pkg::REG_INV_TWO_DX: begin
               inv_two_dx_ff <= csr_port.data[gds_pkg::SCALE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // The front end tracks the raster position, fills the row buffers and forms
   // the four neighbor terms of every result a cell releases.
   gds_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_port),
      .grid_width  (grid_width_ff),
      .grid_height (grid_height_ff),
      .level       (level),
      .push        (push),
      .push_job    (push_job)
   );

   gds_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job),
      .level      (level)
   );

   // The back end scales each term sum; one result word per cycle unless stalled.
   gds_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .inv_two_dx (inv_two_dx_ff),
      .rsp_port   (rsp_port)
   );

endmodule

`default_nettype wire
